// ----- src/dst_pkg.sv -----
// ----------------------------------------------------------------------------
// dst_pkg: shared definitions for the descriptor slot table
// Table geometry, request and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dst_pkg;

    // Table geometry
    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);

    // Channel field widths
    localparam int OPCODE_W    = 2;
    localparam int SLOT_IDX_W  = 6;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic accept;     // take the request on the input channel
        logic scan_step;  // read the next entry of the search sweep
        logic load_out;   // move the staged result into the output register
    } dst_cmd_t;

    typedef struct packed {
        logic is_search;  // request on the input channel is a search
        logic scan_done;  // every entry has been read for the search
        logic out_free;   // output register can take a result this cycle
    } dst_stat_t;

endpackage

// ----- src/dst_if.sv -----
// ----------------------------------------------------------------------------
// dst_req_if / dst_rsp_if: request and response channels
// Valid/ready channels carrying a table request and its single result.
// ----------------------------------------------------------------------------
interface dst_req_if;
    import dst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [HANDLE_W-1:0]   handle;

    modport source (output valid, output opcode, output slot_index, output handle,
                    input ready);
    modport sink   (input valid, input opcode, input slot_index, input handle,
                    output ready);
endinterface

interface dst_rsp_if;
    import dst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_out;
    logic [HANDLE_W-1:0]   handle_out;
    logic                  found;

    modport source (output valid, output status, output slot_out, output handle_out,
                    output found, input ready);
    modport sink   (input valid, input status, input slot_out, input handle_out,
                    input found, output ready);
endinterface

// ----- src/dst_ctrl.sv -----
// ----------------------------------------------------------------------------
// dst_ctrl: sequencing for the descriptor slot table
// Takes one request, runs the search sweep when needed, hands off the result.
// ----------------------------------------------------------------------------
module dst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dst_pkg::dst_stat_t stat,
    output dst_pkg::dst_cmd_t  cmd,
    output dst_pkg::state_t    state
);
    import dst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.is_search ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
            end
            S_RESP:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ----- src/dst_datapath.sv -----
// ----------------------------------------------------------------------------
// dst_datapath: slot storage, free-slot pick, search compare, result register
// Executes the commands from dst_ctrl and reports progress back to it.
// ----------------------------------------------------------------------------
module dst_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dst_pkg::OPCODE_W-1:0]   opcode,
    input  logic [dst_pkg::SLOT_IDX_W-1:0] slot_index,
    input  logic [dst_pkg::HANDLE_W-1:0]   handle,
    input  dst_pkg::dst_cmd_t              cmd,
    output dst_pkg::dst_stat_t             stat,
    dst_rsp_if.source                      rsp
);
    import dst_pkg::*;

    // Slot storage
    logic [HANDLE_BITS-1:0] mem [SLOTS];
    logic [HANDLE_BITS-1:0] rd_data_reg;
    logic [SLOTS-1:0]       valid_reg;
    logic [SLOTS-1:0]       valid_next;

    // Request decode
    op_t                    op;
    logic [HANDLE_BITS-1:0] key;
    logic [SLOT_W-1:0]      idx;
    logic                   idx_hit;
    logic [SLOT_W-1:0]      free_idx;
    logic                   any_free;

    // Memory port
    logic                   wr_en;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;

    // Search sweep
    logic [HANDLE_BITS-1:0] key_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   cmp_vld_reg;
    logic [SLOT_W-1:0]      cmp_idx_reg;
    logic                   found_reg;
    logic                   found_next;

    // Staged result
    status_t                res_status_reg;
    status_t                res_status_next;
    logic [SLOT_IDX_W-1:0]  res_slot_reg;
    logic [SLOT_IDX_W-1:0]  res_slot_next;
    logic                   res_get_reg;
    logic                   res_get_next;

    // Output register
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SLOT_IDX_W-1:0]  out_slot_reg;
    logic [HANDLE_W-1:0]    out_handle_reg;
    logic                   out_found_reg;

    assign op      = op_t'(opcode);
    assign key     = HANDLE_BITS'(handle);
    assign idx     = SLOT_W'(slot_index);
    assign idx_hit = (32'(slot_index) < 32'(SLOTS)) && valid_reg[idx];

    // Lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign any_free = ~&valid_reg;

    // Request execution
    always_comb
    begin
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_get_next    = res_get_reg;
        wr_en           = 1'b0;
        if (cmd.accept)
        begin
            res_status_next = ST_OK;
            res_slot_next   = '0;
            res_get_next    = 1'b0;
            unique case (op)
                OP_INSERT:
                begin
                    if (any_free)
                    begin
                        wr_en                = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        res_slot_next        = SLOT_IDX_W'(free_idx);
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                OP_GET:
                begin
                    res_get_next    = idx_hit;
                    res_status_next = idx_hit ? ST_OK : ST_BAD;
                end
                OP_DELETE:
                begin
                    if (idx_hit)
                    begin
                        valid_next[idx] = 1'b0;
                    end
                    else
                    begin
                        res_status_next = ST_BAD;
                    end
                end
                OP_SEARCH:
                begin
                    res_status_next = ST_OK;
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    assign rd_en   = (cmd.accept && (op == OP_GET)) || cmd.scan_step;
    assign rd_addr = cmd.accept ? idx : cnt_reg[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[free_idx] <= key;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Search sweep: read one entry a cycle, compare it the cycle after
    always_comb
    begin
        cnt_next   = cnt_reg;
        found_next = found_reg;
        if (cmd.accept)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data_reg == key_reg))
            begin
                found_next = 1'b1;
            end
        end
    end

    assign stat.is_search = (op == OP_SEARCH);
    assign stat.scan_done = (cnt_reg == CNT_W'(SLOTS));
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmd.scan_step;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= key;
        end
        cmp_idx_reg    <= cnt_reg[SLOT_W-1:0];
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_get_reg    <= res_get_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_handle_reg <= res_get_reg ? HANDLE_W'(rd_data_reg) : '0;
            out_found_reg  <= found_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot_out   = out_slot_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.found      = out_found_reg;

endmodule

// ----- src/descriptor_slot_table.sv -----
// ----------------------------------------------------------------------------
// descriptor_slot_table: fixed-capacity descriptor slot table
// Insert into the lowest free slot, get, delete and search of handles.
// ----------------------------------------------------------------------------
// The table holds SLOTS handles, each with a valid mark that reset clears;
// the handle storage itself is a memory with one write port and one read
// port and no reset. One request is taken at a time and gives exactly one
// response. Insert, get and delete go from accept/execute to result hand-off,
// which waits for the response channel to be free: the lowest free slot comes
// from a priority pick over the valid marks, and a get reads the memory in the
// accept cycle. A search sweeps the memory read port over every entry, one per
// cycle, comparing each against the key the cycle after. A new request is taken
// once the previous result sits in the output register, so a stalled response
// does not hold up the next request until its own result is ready. A full
// table answers status 2 on insert and changes nothing; get or delete of an
// empty or out-of-range slot answers 1.
// ----------------------------------------------------------------------------
module descriptor_slot_table (
    input  logic      clk,
    input  logic      rst_n,
    dst_req_if.sink   req,
    dst_rsp_if.source rsp
);
    import dst_pkg::*;

    dst_cmd_t  cmd;
    dst_stat_t stat;
    state_t    state;
    logic      in_ready;

    dst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    dst_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (req.opcode),
        .slot_index (req.slot_index),
        .handle     (req.handle),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (rsp)
    );

    // Take a request only while idle
    assign req.ready = in_ready;

    // Never overwrite a result the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp.valid || rsp.ready))
        else $error("result register overwritten while stalled");

    // The search sweep never overlaps a new request
    a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (!req.ready && state == S_SCAN))
        else $error("search sweep active while taking requests");

    // One request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken before result hand-off");

endmodule

// ----- test/descriptor_slot_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_table_tb: self-checking bench for the descriptor slot table
// Drives insert, get, delete and search requests through the request channel,
// predicts each response from a local copy of the slot table, and checks every
// response in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module descriptor_slot_table_tb;
    import dst_pkg::*;

    localparam int CLK_PERIOD   = 8;
    // A search sweeps every entry, so it is the slowest request.
    localparam int DRAIN_CYCLES = SLOTS + 16;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 8;

    // One expected response, field for field as it leaves the block.
    typedef struct {
        status_t               status;
        logic [SLOT_IDX_W-1:0] slot_out;
        logic [HANDLE_W-1:0]   handle_out;
        logic                  found;
    } slot_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    dst_req_if req_ch();
    dst_rsp_if rsp_ch();

    descriptor_slot_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the table: handle storage plus the valid marks.
    // ------------------------------------------------------------------------
    logic [HANDLE_BITS-1:0] model_handle [SLOTS];
    bit                     model_used   [SLOTS];

    // Responses still owed by the block, oldest first.
    slot_rsp_t pending_responses [$];
    int        mismatch_count = 0;

    // Handles that recur, so searches hit and duplicates land in the table.
    logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

    // Sender burst state: requests left in the current burst.
    int burst_left = 0;

    // Receiver stall pattern: mode and cycles left in it.
    int stall_mode = 0;
    int mode_left  = 0;

    // ------------------------------------------------------------------------
    // Apply one request to the shadow table and return the response it gives.
    // ------------------------------------------------------------------------
    function automatic slot_rsp_t table_response(op_t op, logic [SLOT_IDX_W-1:0] idx,
                                                 logic [HANDLE_W-1:0] h);
        slot_rsp_t              r;
        logic [HANDLE_BITS-1:0] key;
        int                     free_slot;
        r = '{ST_OK, '0, '0, 1'b0};
        key = HANDLE_BITS'(h);
        free_slot = -1;
        case (op)
            OP_INSERT:
            begin
                // Lowest free slot wins; a full table changes nothing.
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!model_used[i])
                        free_slot = i;
                if (free_slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    model_used[free_slot]   = 1'b1;
                    model_handle[free_slot] = key;
                    r.slot_out = SLOT_IDX_W'(free_slot);
                end
            end
            OP_GET:
            begin
                if (int'(idx) < SLOTS && model_used[idx])
                    r.handle_out = HANDLE_W'(model_handle[idx]);
                else
                    r.status = ST_BAD;
            end
            OP_DELETE:
            begin
                if (int'(idx) < SLOTS && model_used[idx])
                    model_used[idx] = 1'b0;
                else
                    r.status = ST_BAD;
            end
            default:
            begin
                // Only slots with their valid mark set take part in the compare.
                for (int i = 0; i < SLOTS; i++)
                    if (model_used[i] && model_handle[i] == key)
                        r.found = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic int used_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            n += model_used[i];
        return n;
    endfunction

    // Random slot that currently holds a handle, or any slot if none does.
    function automatic logic [SLOT_IDX_W-1:0] pick_used_slot();
        int held [$];
        for (int i = 0; i < SLOTS; i++)
            if (model_used[i])
                held.push_back(i);
        if (held.size() == 0)
            return SLOT_IDX_W'($urandom_range(0, SLOTS - 1));
        return SLOT_IDX_W'(held[$urandom_range(0, held.size() - 1)]);
    endfunction

    // Handle that sits in the table right now, or a random one if it is empty.
    function automatic logic [HANDLE_W-1:0] pick_held_handle();
        logic [SLOT_IDX_W-1:0] s;
        s = pick_used_slot();
        if (model_used[s])
            return HANDLE_W'(model_handle[s]);
        return $urandom;
    endfunction

    // Pool handle two times in five, a fresh random one otherwise.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 4) < 2)
            return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Send one request. Hold valid across a burst; at the end of a burst drop
    // valid for a random gap. The expected response is recorded at the edge
    // that accepts the request, so the shadow table follows the block's order.
    // ------------------------------------------------------------------------
    task automatic send_request(op_t op, logic [SLOT_IDX_W-1:0] idx,
                                logic [HANDLE_W-1:0] h);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.slot_index <= idx;
        req_ch.handle     <= h;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_responses.push_back(table_response(op, idx, h));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12)
                                              : $urandom_range(1, 3);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic wait_all_responses();
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every lookup on an empty table: bad descriptor, nothing found.
    task automatic test_empty_table();
        send_request(OP_GET,    6'd0,  '0);
        send_request(OP_GET,    6'd63, '0);
        send_request(OP_DELETE, 6'd0,  '0);
        send_request(OP_DELETE, 6'd63, '0);
        send_request(OP_SEARCH, 6'd0,  32'h0000_0000);
        send_request(OP_SEARCH, 6'd0,  32'hFFFF_FFFF);
        wait_all_responses();
    endtask

    // Insert the extreme handles, read them back, free one and refill it.
    task automatic test_basic_ops();
        send_request(OP_INSERT, 6'd63, 32'h0000_0000);
        send_request(OP_INSERT, 6'd0,  32'hFFFF_FFFF);
        send_request(OP_INSERT, 6'd0,  32'h8000_0001);
        send_request(OP_GET,    6'd0,  32'hFFFF_FFFF);
        send_request(OP_GET,    6'd1,  '0);
        send_request(OP_GET,    6'd2,  '0);
        // Handle zero is an ordinary value: a held zero must be found.
        send_request(OP_SEARCH, 6'd0,  32'h0000_0000);
        send_request(OP_SEARCH, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 6'd1,  '0);
        send_request(OP_GET,    6'd1,  '0);
        // Second delete of the same slot reports bad descriptor.
        send_request(OP_DELETE, 6'd1,  '0);
        send_request(OP_SEARCH, 6'd0,  32'hFFFF_FFFF);
        // Freed slot 1 is now the lowest free one.
        send_request(OP_INSERT, 6'd0,  32'h5A5A_A5A5);
        send_request(OP_GET,    6'd1,  '0);
        send_request(OP_GET,    6'd3,  '0);
        send_request(OP_DELETE, 6'd0,  '0);
        wait_all_responses();
    endtask

    // Fill the table, overflow it, read and search it, punch random holes and
    // refill them so the lowest-free pick sees scattered free slots.
    task automatic test_fill_and_refill();
        int holes;
        while (used_count() < SLOTS)
            send_request(OP_INSERT, SLOT_IDX_W'($urandom), pick_handle());
        repeat ($urandom_range(2, 4))
            send_request(OP_INSERT, SLOT_IDX_W'($urandom), $urandom);
        repeat (8)
            send_request(OP_GET, SLOT_IDX_W'($urandom), $urandom);
        repeat (3)
            send_request(OP_SEARCH, SLOT_IDX_W'($urandom), pick_held_handle());
        send_request(OP_SEARCH, SLOT_IDX_W'($urandom), $urandom);
        holes = $urandom_range(4, 40);
        repeat (holes)
            send_request(OP_DELETE, SLOT_IDX_W'($urandom), $urandom);
        repeat ($urandom_range(2, 6))
            send_request(OP_GET, SLOT_IDX_W'($urandom), $urandom);
        repeat ($urandom_range(holes / 2, holes))
            send_request(OP_INSERT, SLOT_IDX_W'($urandom), pick_handle());
        repeat (2)
            send_request(OP_SEARCH, SLOT_IDX_W'($urandom), pick_held_handle());
        wait_all_responses();
    endtask

    // Weighted random mix; get and delete mostly name a held slot.
    task automatic test_random_mix(int count);
        int                    pick;
        logic [SLOT_IDX_W-1:0] idx;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 3) != 0) ? pick_used_slot()
                                               : SLOT_IDX_W'($urandom);
            if (pick < 30)
                send_request(OP_INSERT, idx, pick_handle());
            else if (pick < 55)
                send_request(OP_GET, idx, $urandom);
            else if (pick < 80)
                send_request(OP_DELETE, idx, $urandom);
            else if (pick < 90)
                send_request(OP_SEARCH, idx, pick_held_handle());
            else
                send_request(OP_SEARCH, idx, pick_handle());
        end
        wait_all_responses();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check the response taken at this edge against the oldest
    // expectation, then choose ready for the next cycle. The stall pattern
    // switches among always ready, coin flip and long stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_monitor
        slot_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with no request outstanding", $realtime);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.slot_out !== want.slot_out ||
                    rsp_ch.handle_out !== want.handle_out || rsp_ch.found !== want.found)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: exp/act status %0d/%0d slot %0d/%0d h %h/%h f %0b/%0b",
                                 $realtime, want.status, rsp_ch.status, want.slot_out,
                                 rsp_ch.slot_out, want.handle_out, rsp_ch.handle_out,
                                 want.found, rsp_ch.found);
                end
            end
        end

        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 60);
        end
        else
            mode_left--;

        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_INSERT;
        req_ch.slot_index <= '0;
        req_ch.handle     <= '0;

        for (int i = 0; i < SLOTS; i++)
        begin
            model_used[i]   = 1'b0;
            model_handle[i] = '0;
        end
        handle_pool[0] = 32'h0000_0000;
        handle_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            handle_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_basic_ops();
        repeat (3)
            test_fill_and_refill();
        test_random_mix(830);

        // Let any stray response show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("[descriptor_slot_table] OK");
        else
            $display("[descriptor_slot_table] ERROR");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("[descriptor_slot_table] ERROR");
        $finish;
    end

endmodule
